// File: rtl/core/ntt_pair_basemul_montgomery_unit_macros.svh
// ============================================================================
// NTT pair base multiplier assertion macros
// Shared assertion forms for the checker of the base multiplication unit.
// ============================================================================
`ifndef NTT_PAIR_BASEMUL_MONTGOMERY_UNIT_MACROS_SVH
`define NTT_PAIR_BASEMUL_MONTGOMERY_UNIT_MACROS_SVH

// Assertion that is switched off while the reset is held.
`define NTT_PBM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that stays active through the reset.
`define NTT_PBM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/ntt_pbm_pkg.sv
// ============================================================================
// NTT pair base multiplier package
// Widths, constants and types shared by the base multiplication modules.
// ============================================================================
package ntt_pbm_pkg;

    localparam int COEFF_W = 16;
    localparam int PROD_W  = 2 * COEFF_W;

    // Stages of one Montgomery multiplier, and of the whole pipeline:
    // two chained multipliers and one final adder stage.
    localparam int MM_STAGES  = 4;
    localparam int NUM_STAGES = 2 * MM_STAGES + 1;

    // q^-1 mod 2^16 for the default modulus.
    localparam logic signed [COEFF_W-1:0] QINV = -16'sd767;

    typedef logic signed [COEFF_W-1:0] coeff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic [NUM_STAGES-1:0]     stage_en_t;
    typedef logic [MM_STAGES-1:0]      mm_en_t;

endpackage

// File: rtl/core/ntt_pbm_mont_mul.sv
// ============================================================================
// Montgomery multiplier
// Four-stage signed 16x16 multiply followed by Montgomery reduction, R = 2^16.
// ============================================================================
module ntt_pbm_mont_mul
    import ntt_pbm_pkg::*;
#(
    parameter int MODULUS = 769
) (
    input  logic   aclk,
    input  mm_en_t en,
    input  coeff_t op_a,
    input  coeff_t op_b,
    output coeff_t result
);

    localparam coeff_t MOD_C = COEFF_W'(MODULUS);

    prod_t  x1_reg, x1_next;
    prod_t  x2_reg;
    coeff_t t_reg, t_next;
    prod_t  x3_reg;
    prod_t  tm_reg, tm_next;
    coeff_t r_reg, r_next;
    prod_t  diff;

    always_comb begin
        x1_next = prod_t'(op_a) * prod_t'(op_b);
        // Only the low half of x matters for the correction factor.
        t_next  = coeff_t'(x1_reg[COEFF_W-1:0] * QINV);
        tm_next = prod_t'(t_reg) * prod_t'(MOD_C);
        // The low half cancels; the upper half is the floor shift.
        diff    = x3_reg - tm_reg;
        r_next  = diff[PROD_W-1:COEFF_W];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x1_reg <= x1_next;
        end
        if (en[1]) begin
            x2_reg <= x1_reg;
            t_reg  <= t_next;
        end
        if (en[2]) begin
            x3_reg <= x2_reg;
            tm_reg <= tm_next;
        end
        if (en[3]) begin
            r_reg <= r_next;
        end
    end

    assign result = r_reg;

endmodule

// File: rtl/core/ntt_pbm_pipe_ctrl.sv
// ============================================================================
// Pipeline control
// Valid bits and per-stage load enables with bubble removal under stall.
// ============================================================================
module ntt_pbm_pipe_ctrl
    import ntt_pbm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      m_tready,
    output logic      s_tready,
    output logic      m_tvalid,
    output stage_en_t en
);

    stage_en_t valid_reg, valid_next;

    always_comb begin
        // A stage loads when it is empty or the stage after it moves on.
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next = valid_reg;
        if (en[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

endmodule

// File: rtl/core/ntt_pair_basemul_montgomery_unit.sv
// ============================================================================
// NTT pair base multiplier
// Product of two degree-one polynomials modulo X^2 - zeta, Montgomery form.
// ============================================================================
// The unit takes one transaction per clock cycle unless the output side
// stalls, and returns one result transaction for each input, in order. Each
// input holds the coefficients a0, a1, b0, b1 and the twist zeta, all signed
// 16-bit. The outputs are r0 = mont(mont(a1*b1)*zeta) + mont(a0*b0) and
// r1 = mont(a0*b1) + mont(a1*b0), where mont(x) is the signed Montgomery
// reduction with R = 2^16 and the inverse constant -767; both sums wrap to
// 16 bits. The pipeline holds two chained four-stage Montgomery multipliers
// (the twist multiply needs the reduced a1*b1) plus one adder stage. Every
// stage holds a valid bit; when the output stalls, empty stages still fill,
// so the unit keeps accepting until the pipeline is full. There is no
// configuration and no state kept between transactions.
module ntt_pair_basemul_montgomery_unit
    import ntt_pbm_pkg::*;
#(
    parameter int MODULUS = 769
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // a_const_term[15:0], a_linear_term[31:16], b_const_term[47:32],
    // b_linear_term[63:48], twist_factor[79:64]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // prod_const_term[15:0], prod_linear_term[31:16]
    output logic [31:0] m_tdata
);

    localparam int L2 = MM_STAGES;        // first stage of the twist multiplier
    localparam int LAST = NUM_STAGES - 1; // final adder stage

    stage_en_t en;

    coeff_t a_const_term, a_linear_term, b_const_term, b_linear_term, twist_factor;

    // Reduced partial products from the first multiplier layer.
    coeff_t hi_red, c0_red, x0_red, x1_red;
    coeff_t tw_red;

    // Values that ride alongside the multipliers.
    coeff_t zeta_d_reg [MM_STAGES];
    coeff_t c0_d_reg   [MM_STAGES];
    coeff_t r1_d_reg   [MM_STAGES];
    coeff_t r1_next;
    coeff_t prod_const_reg, prod_const_next;
    coeff_t prod_linear_reg;

    assign a_const_term  = s_tdata[15:0];
    assign a_linear_term = s_tdata[31:16];
    assign b_const_term  = s_tdata[47:32];
    assign b_linear_term = s_tdata[63:48];
    assign twist_factor  = s_tdata[79:64];

    ntt_pbm_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .en       (en)
    );

    // First layer: the four cross products, all in parallel.
    ntt_pbm_mont_mul #(.MODULUS(MODULUS)) u_mm_hi (
        .aclk (aclk), .en (en[MM_STAGES-1:0]),
        .op_a (a_linear_term), .op_b (b_linear_term), .result (hi_red)
    );
    ntt_pbm_mont_mul #(.MODULUS(MODULUS)) u_mm_c0 (
        .aclk (aclk), .en (en[MM_STAGES-1:0]),
        .op_a (a_const_term), .op_b (b_const_term), .result (c0_red)
    );
    ntt_pbm_mont_mul #(.MODULUS(MODULUS)) u_mm_x0 (
        .aclk (aclk), .en (en[MM_STAGES-1:0]),
        .op_a (a_const_term), .op_b (b_linear_term), .result (x0_red)
    );
    ntt_pbm_mont_mul #(.MODULUS(MODULUS)) u_mm_x1 (
        .aclk (aclk), .en (en[MM_STAGES-1:0]),
        .op_a (a_linear_term), .op_b (b_const_term), .result (x1_red)
    );

    // Second layer: twist the reduced a1*b1 by zeta.
    ntt_pbm_mont_mul #(.MODULUS(MODULUS)) u_mm_tw (
        .aclk (aclk), .en (en[L2+MM_STAGES-1:L2]),
        .op_a (hi_red), .op_b (zeta_d_reg[MM_STAGES-1]), .result (tw_red)
    );

    always_comb begin
        r1_next         = x0_red + x1_red;
        prod_const_next = tw_red + c0_d_reg[MM_STAGES-1];
    end

    always_ff @(posedge aclk) begin
        // zeta follows the first layer so it meets the reduced a1*b1.
        if (en[0]) begin
            zeta_d_reg[0] <= twist_factor;
        end
        for (int i = 1; i < MM_STAGES; i++) begin
            if (en[i]) begin
                zeta_d_reg[i] <= zeta_d_reg[i-1];
            end
        end
        // The a0*b0 term and the linear sum follow the second layer.
        if (en[L2]) begin
            c0_d_reg[0] <= c0_red;
            r1_d_reg[0] <= r1_next;
        end
        for (int i = 1; i < MM_STAGES; i++) begin
            if (en[L2+i]) begin
                c0_d_reg[i] <= c0_d_reg[i-1];
                r1_d_reg[i] <= r1_d_reg[i-1];
            end
        end
        if (en[LAST]) begin
            prod_const_reg  <= prod_const_next;
            prod_linear_reg <= r1_d_reg[MM_STAGES-1];
        end
    end

    assign m_tdata = {prod_linear_reg, prod_const_reg};

endmodule

// File: rtl/core/ntt_pbm_checker.sv
// ============================================================================
// NTT pair base multiplier checker
// Port-level assertions on reset, output hold and ready propagation.
// ============================================================================
`include "ntt_pair_basemul_montgomery_unit_macros.svh"

module ntt_pbm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A reset leaves no result transaction pending.
    `NTT_PBM_ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !m_tvalid, "valid after reset")

    // A stalled result holds its value.
    `NTT_PBM_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "result changed under stall")

    // When the output stage can move, every stage can, so the input is ready.
    `NTT_PBM_ASSERT(a_ready_flow, aclk, aresetn,
        (m_tready || !m_tvalid) |-> s_tready, "input stalled with free output")

    // With no result at the output and no input offered before, the input is ready.
    `NTT_PBM_ASSERT(a_empty_ready, aclk, aresetn,
        $past(!s_tvalid) && !m_tvalid |-> s_tready, "empty pipeline not ready")

endmodule

bind ntt_pair_basemul_montgomery_unit ntt_pbm_checker u_ntt_pbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
